FILE: rtl/srvramp_pkg.sv
// ----------------------------------------------------------------------------
// srvramp_pkg
// Shared types, constants and the angle conversion for the servo ramp core.
// ----------------------------------------------------------------------------
package srvramp_pkg;

  // Default width of a compare value.
  localparam int CMP_WIDTH_DEF = 16;

  // Field widths of the streams.
  localparam int FIELD_W    = 16;
  localparam int NUM_CH     = 3;
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 56;

  // Compare value after reset and the limits of the angle mapping.
  localparam int RESET_CMP     = 1875;
  localparam int ANGLE_MIN_CMP = 1250;
  localparam int ANGLE_MAX_CMP = 2500;
  localparam int ANGLE_LIMIT   = 90;
  localparam int ANGLE_SPAN    = 180;

  // floor(v * 1250 / 180) is formed as (v * ANGLE_RECIP) >> ANGLE_SHIFT.
  // The rounding error stays below one for every v in 0..180.
  localparam int ANGLE_SHIFT = 16;
  localparam int ANGLE_RECIP =
      ((1 << ANGLE_SHIFT) * ANGLE_MIN_CMP + ANGLE_SPAN - 1) / ANGLE_SPAN;
  localparam int ANGLE_CMP_W = 12;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_ANGLE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    JSEL_NONE  = 2'd0,
    JSEL_BASE  = 2'd1,
    JSEL_LOWER = 2'd2,
    JSEL_UPPER = 2'd3
  } joint_sel_t;

  // Maps an angle in degrees to a compare value, clamped to the servo range.
  function automatic logic [ANGLE_CMP_W-1:0] angle_to_cmp(input logic signed [15:0] angle);
    logic signed [15:0] shifted;
    logic [7:0]         v;
    logic [26:0]        prod;
    logic [ANGLE_CMP_W-1:0] res;
    shifted = angle + 16'(ANGLE_LIMIT);
    v       = shifted[7:0];
    prod    = 27'(v) * 27'(ANGLE_RECIP);
    res     = ANGLE_CMP_W'(prod[26:ANGLE_SHIFT]) + ANGLE_CMP_W'(ANGLE_MIN_CMP);
    if (angle > 16'sd90) begin
      res = ANGLE_CMP_W'(ANGLE_MAX_CMP);
    end else if (angle < -16'sd90) begin
      res = ANGLE_CMP_W'(ANGLE_MIN_CMP);
    end
    return res;
  endfunction

endpackage

FILE: rtl/servo_ramp_controller_3ch_core.sv
// ----------------------------------------------------------------------------
// servo_ramp_controller_3ch_core
// Slew-rate limiter for the compare values of three servo PWM channels.
// ----------------------------------------------------------------------------
// The core keeps the compare values of three servo channels (base, lower
// joint, upper joint) and ramps them toward destinations at a fixed step per
// tick. Every item produces exactly one result that reports the three compare
// values and a moving flag after the item has taken effect. A tick item moves
// each channel that is not done by its step; a step that would pass the
// destination lands on it and marks the channel done, and a channel found at
// its destination is marked done. A start item loads destinations and steps
// without moving anything. A set-angle item writes a compare value derived
// from the clamped angle to the selected channel. Items pass through an input
// register and a result register. An item enters the input register at the
// edge that accepts it; its result enters the result register, which raises
// out_tvalid, once that register is free or drains. The core takes one item
// per clock while out_tready stays high. The only limit on throughput is the
// downstream tready: while a finished result waits, the input register takes
// at most one more item and then holds in_tready low until the result drains.
module servo_ramp_controller_3ch_core
  import srvramp_pkg::*;
#(
  parameter int COMPARE_WIDTH = CMP_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: angle_deg, dest_base, dest_lower, dest_upper,
  // step_base, step_lower, step_upper (16 bits each).
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: action (2 bits), joint_select (2 bits).
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: base_compare, lower_compare, upper_compare (16 bits
  // each), moving (1 bit), zero fill to 56 bits.
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int CW = COMPARE_WIDTH;
  // Working width wide enough for a compare value plus a 16-bit step.
  localparam int SW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;
  localparam logic [CW-1:0] RESET_VAL = CW'(RESET_CMP);

  // Input register.
  logic                    stg_vld_r;
  action_t                 stg_act_r;
  joint_sel_t              stg_sel_r;
  logic signed [15:0]      stg_angle_r;
  logic [FIELD_W-1:0]      stg_dest_r [NUM_CH];
  logic [FIELD_W-1:0]      stg_step_r [NUM_CH];

  // Channel state.
  logic [CW-1:0]           cmp_r  [NUM_CH];
  logic [CW-1:0]           cmp_nxt[NUM_CH];
  logic [CW-1:0]           tgt_r  [NUM_CH];
  logic [CW-1:0]           tgt_nxt[NUM_CH];
  logic [FIELD_W-1:0]      step_r  [NUM_CH];
  logic [FIELD_W-1:0]      step_nxt[NUM_CH];
  logic [NUM_CH-1:0]       done_r;
  logic [NUM_CH-1:0]       done_nxt;

  // Result register.
  logic                    out_vld_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [OUT_DATA_W-1:0]   out_data_nxt;

  logic                    adv;
  logic [CW-1:0]           tick_cmp [NUM_CH];
  logic [NUM_CH-1:0]       tick_done;
  logic [CW-1:0]           angle_val;

  // The staged item moves on whenever the result register is free or drains.
  assign adv       = stg_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !stg_vld_r || adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign angle_val = CW'(angle_to_cmp(stg_angle_r));

  // One tick of the ramp for each channel, in parallel.
  always_comb begin
    logic [SW-1:0] cur_x;
    logic [SW-1:0] dst_x;
    logic [SW-1:0] stp_x;
    logic [SW-1:0] sum_x;
    logic [SW-1:0] diff_x;
    logic [SW-1:0] sub_x;
    for (int i = 0; i < NUM_CH; i++) begin
      cur_x  = SW'(cmp_r[i]);
      dst_x  = SW'(tgt_r[i]);
      stp_x  = SW'(step_r[i]);
      sum_x  = cur_x + stp_x;
      diff_x = cur_x - dst_x;
      sub_x  = cur_x - stp_x;
      tick_cmp[i]  = cmp_r[i];
      tick_done[i] = done_r[i];
      if (!done_r[i]) begin
        if (cur_x < dst_x) begin
          if (sum_x > dst_x) begin
            tick_cmp[i]  = tgt_r[i];
            tick_done[i] = 1'b1;
          end else begin
            tick_cmp[i] = sum_x[CW-1:0];
          end
        end else if (cur_x > dst_x) begin
          if (stp_x > diff_x) begin
            tick_cmp[i]  = tgt_r[i];
            tick_done[i] = 1'b1;
          end else begin
            tick_cmp[i] = sub_x[CW-1:0];
          end
        end else begin
          tick_done[i] = 1'b1;
        end
      end
    end
  end

  // Next channel state for the staged item.
  always_comb begin
    logic [SW-1:0] dest_x;
    cmp_nxt  = cmp_r;
    tgt_nxt  = tgt_r;
    step_nxt = step_r;
    done_nxt = done_r;
    dest_x   = '0;
    case (stg_act_r)
      ACT_TICK: begin
        cmp_nxt  = tick_cmp;
        done_nxt = tick_done;
      end
      ACT_START: begin
        for (int i = 0; i < NUM_CH; i++) begin
          dest_x      = SW'(stg_dest_r[i]);
          tgt_nxt[i]  = dest_x[CW-1:0];
          step_nxt[i] = stg_step_r[i];
          done_nxt[i] = (stg_step_r[i] == '0);
        end
      end
      ACT_ANGLE: begin
        case (stg_sel_r)
          JSEL_BASE:  cmp_nxt[0] = angle_val;
          JSEL_LOWER: cmp_nxt[1] = angle_val;
          JSEL_UPPER: cmp_nxt[2] = angle_val;
          default:    ;
        endcase
      end
      default: ;
    endcase
  end

  // Result word built from the updated state.
  always_comb begin
    logic [SW-1:0] val_x;
    out_data_nxt = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      val_x = SW'(cmp_nxt[i]);
      out_data_nxt[i*FIELD_W +: FIELD_W] = val_x[FIELD_W-1:0];
    end
    out_data_nxt[NUM_CH*FIELD_W] = !(&done_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      done_r    <= '1;
      for (int i = 0; i < NUM_CH; i++) begin
        cmp_r[i]  <= RESET_VAL;
        tgt_r[i]  <= '0;
        step_r[i] <= '0;
      end
    end else begin
      if (in_tready) begin
        stg_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (adv) begin
        cmp_r  <= cmp_nxt;
        tgt_r  <= tgt_nxt;
        step_r <= step_nxt;
        done_r <= done_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_act_r   <= action_t'(in_tuser[1:0]);
      stg_sel_r   <= joint_sel_t'(in_tuser[3:2]);
      stg_angle_r <= in_tdata[15:0];
      for (int i = 0; i < NUM_CH; i++) begin
        stg_dest_r[i] <= in_tdata[(i+1)*FIELD_W +: FIELD_W];
        stg_step_r[i] <= in_tdata[(i+4)*FIELD_W +: FIELD_W];
      end
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  // While a result is stalled nothing is processed, so the state holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> ($stable(done_r) && $stable(cmp_r[0])))
    else $error("channel state changed while the result was stalled");

  // Only a start item can clear a done flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (stg_act_r != ACT_START)) |=> ((done_r & $past(done_r)) == $past(done_r)))
    else $error("done flag cleared by an item other than start");

  // An empty input register always takes an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    !stg_vld_r |-> in_tready)
    else $error("input stalled with an empty input register");

  // A published result reports moving exactly when some done flag is clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_data_r[NUM_CH*FIELD_W] == !(&done_r)))
    else $error("moving flag disagrees with the done flags");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-channel servo ramp core. A directed table
// covers reset values, angle clamping, the ignored selector, exact landing,
// overshoot clamping and zero steps. Random items follow. Results without a
// golden value are compared with a behavioral model of the ramp in this bench.
// ----------------------------------------------------------------------------
module tb;
  import srvramp_pkg::*;

  // The action field is two bits wide; its fourth code changes nothing and
  // only reports the current state.
  localparam logic [1:0] ACT_HOLD = 2'd3;

  // Items counted toward the random part before idling stops, and in total.
  localparam int QUIET_FROM  = 1750;
  localparam int RANDOM_ITEMS = 1950;

  // One input item as the bench sees it, before packing onto the stream.
  typedef struct packed {
    logic [1:0]         action;
    joint_sel_t         jsel;
    logic signed [15:0] angle;
    logic [2:0][15:0]   dest;
    logic [2:0][15:0]   step;
  } servo_cmd_t;

  // One result item: compare values of base, lower and upper, and the flag.
  typedef struct packed {
    logic [2:0][15:0] cmp;
    logic             moving;
  } servo_report_t;

  // A row of the directed table. Rows with a hand-written result carry it in
  // golden; all other rows are checked against the model.
  typedef struct packed {
    servo_cmd_t    cmd;
    logic          typed;
    servo_report_t golden;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // Fields from bit 0: angle_deg, dest_base, dest_lower, dest_upper,
  // step_base, step_lower, step_upper (16 bits each).
  logic [IN_DATA_W-1:0]  in_tdata;
  // Fields from bit 0: action (2 bits), joint_select (2 bits).
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // Fields from bit 0: base_compare, lower_compare, upper_compare (16 bits
  // each), moving (1 bit), zero fill to 56 bits.
  logic [OUT_DATA_W-1:0] out_tdata;

  servo_ramp_controller_3ch_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Model state: compare values, destinations, steps and done flags of the
  // three channels, in the order base, lower, upper.
  logic [2:0][15:0] model_cmp;
  logic [2:0][15:0] model_dest;
  logic [2:0][15:0] model_step;
  logic [2:0]       model_done;

  // Results still owed by the core, oldest first.
  servo_report_t pending_reports [$];

  dir_row_t dir_table [$];
  string    ch_name [3] = '{"base", "lower", "upper"};

  // Once set, neither side of the stream idles any more.
  bit quiet;
  int n_fail;
  int n_checked;
  int n_tick, n_start, n_angle, n_hold;

  // --------------------------------------------------------------------------
  // Clock. The period is 2 ns.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral model of the core. It applies one item to the model state and
  // returns the result that the item causes.
  // --------------------------------------------------------------------------
  task automatic advance_servo_model(input servo_cmd_t c, output servo_report_t r);
    logic [16:0] sum;
    int          a;
    int          v;
    case (c.action)
      ACT_TICK: begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (!model_done[ch]) begin
            if (model_cmp[ch] < model_dest[ch]) begin
              // The sum is formed one bit wider, so an upward step past the
              // top of the range is seen as an overshoot and not a wrap.
              sum = {1'b0, model_cmp[ch]} + {1'b0, model_step[ch]};
              if (sum > {1'b0, model_dest[ch]}) begin
                model_cmp[ch]  = model_dest[ch];
                model_done[ch] = 1'b1;
              end else begin
                model_cmp[ch] = sum[15:0];
              end
            end else if (model_cmp[ch] > model_dest[ch]) begin
              if (model_step[ch] > model_cmp[ch] - model_dest[ch]) begin
                model_cmp[ch]  = model_dest[ch];
                model_done[ch] = 1'b1;
              end else begin
                model_cmp[ch] = model_cmp[ch] - model_step[ch];
              end
            end else begin
              // Found at the destination: done, value unchanged.
              model_done[ch] = 1'b1;
            end
          end
        end
      end
      ACT_START: begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          model_dest[ch] = c.dest[ch];
          model_step[ch] = c.step[ch];
          model_done[ch] = (c.step[ch] == 16'd0);
        end
      end
      ACT_ANGLE: begin
        if (c.jsel != JSEL_NONE) begin
          a = int'(c.angle);
          if (a > ANGLE_LIMIT) begin
            v = ANGLE_MAX_CMP;
          end else if (a < -ANGLE_LIMIT) begin
            v = ANGLE_MIN_CMP;
          end else begin
            v = (a + ANGLE_LIMIT) * ANGLE_MIN_CMP / ANGLE_SPAN + ANGLE_MIN_CMP;
          end
          model_cmp[int'(c.jsel) - 1] = 16'(v);
        end
      end
      default: begin
      end
    endcase
    r.cmp    = model_cmp;
    r.moving = ~&model_done;
  endtask

  // Builds one directed row; the golden values matter only when typed is set.
  function automatic dir_row_t dir_row(input logic [1:0] act, input joint_sel_t js,
                                       input int ang, input int d0, input int d1,
                                       input int d2, input int s0, input int s1,
                                       input int s2, input bit typed, input int g0,
                                       input int g1, input int g2, input bit gm);
    dir_row_t r;
    r.cmd.action  = act;
    r.cmd.jsel    = js;
    r.cmd.angle   = 16'(ang);
    r.cmd.dest    = {16'(d2), 16'(d1), 16'(d0)};
    r.cmd.step    = {16'(s2), 16'(s1), 16'(s0)};
    r.typed       = typed;
    r.golden.cmp  = {16'(g2), 16'(g1), 16'(g0)};
    r.golden.moving = gm;
    return r;
  endfunction

  // Draws one random item. Most are well-formed commands with random content;
  // a few are fully random noise. Fields an action ignores are random too.
  function automatic servo_cmd_t random_cmd();
    servo_cmd_t c;
    int         pick;
    c.action = 2'($urandom_range(0, 3));
    c.jsel   = joint_sel_t'($urandom_range(0, 3));
    c.angle  = 16'($urandom);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      c.dest[ch] = 16'($urandom);
      c.step[ch] = 16'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      c.action = ACT_TICK;
    end else if (pick < 72) begin
      c.action = ACT_START;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        // Destinations mostly sit in the servo range; steps are mostly short
        // so that ramps take several ticks, with zero and huge steps mixed in.
        if ($urandom_range(0, 9) < 7) begin
          c.dest[ch] = 16'($urandom_range(1000, 2700));
        end
        case ($urandom_range(0, 19))
          0, 1, 2:    c.step[ch] = 16'd0;
          3, 4, 5:    c.step[ch] = 16'($urandom_range(65, 2000));
          6, 7:       c.step[ch] = 16'($urandom);
          default:    c.step[ch] = 16'($urandom_range(1, 64));
        endcase
      end
    end else if (pick < 92) begin
      c.action = ACT_ANGLE;
      if ($urandom_range(0, 4) != 0) begin
        c.angle = 16'($urandom_range(0, 240) - 120);
      end
    end else if (pick < 95) begin
      c.action = ACT_HOLD;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Called at a falling edge; an optional idle gap with tvalid low comes
  // first, then the item is held until the core takes it. The expected result
  // is queued at the accepting rising edge, and the task returns at the next
  // falling edge so that tvalid can stay high for a following item.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input servo_cmd_t c, input bit typed,
                          input servo_report_t golden);
    servo_report_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tdata  = {c.step[2], c.step[1], c.step[0], c.dest[2], c.dest[1], c.dest[0],
                 c.angle};
    in_tuser  = {c.jsel, c.action};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_servo_model(c, predicted);
    pending_reports.push_back(typed ? golden : predicted);
    case (c.action)
      ACT_TICK:  n_tick++;
      ACT_START: n_start++;
      ACT_ANGLE: n_angle++;
      default:   n_hold++;
    endcase
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. tready drops in random bursts with long stretches of steady
  // readiness between them, until the quiet phase.
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    hold       = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && hold == 0 && $urandom_range(0, 15) == 0) begin
        hold = $urandom_range(1, 11);
      end
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker. Each accepted result is compared field by field with the oldest
  // expectation; a result with nothing waiting is a failure of its own.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    servo_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result %h with no item outstanding", out_tdata);
        n_fail++;
      end else begin
        want = pending_reports.pop_front();
        n_checked++;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (out_tdata[16*ch +: 16] !== want.cmp[ch]) begin
            $error("%s_compare expected %0d got %0d", ch_name[ch], want.cmp[ch],
                   out_tdata[16*ch +: 16]);
            n_fail++;
          end
        end
        if (out_tdata[48] !== want.moving) begin
          $error("moving expected %0d got %0d", want.moving, out_tdata[48]);
          n_fail++;
        end
        if (out_tdata[OUT_DATA_W-1:49] !== '0) begin
          $error("fill expected 0 got %0h", out_tdata[OUT_DATA_W-1:49]);
          n_fail++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random items, drain and verdict.
  // --------------------------------------------------------------------------
  initial begin
    servo_cmd_t    c;
    servo_report_t none;
    int            counted;
    none      = '0;
    quiet     = 1'b0;
    n_fail    = 0;
    n_checked = 0;
    n_tick    = 0;
    n_start   = 0;
    n_angle   = 0;
    n_hold    = 0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 1'b0;
    model_cmp  = {3{16'(RESET_CMP)}};
    model_dest = '0;
    model_step = '0;
    model_done = 3'b111;

    // Directed rows. The first ones read straight off the reset state and the
    // angle clamp; the ramp rows after them are left to the model.
    // Reset state, seen through a tick and through the no-op action.
    dir_table.push_back(dir_row(ACT_TICK, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                1, 1875, 1875, 1875, 0));
    dir_table.push_back(dir_row(ACT_HOLD, JSEL_UPPER, 0, 0, 0, 0, 0, 0, 0,
                                1, 1875, 1875, 1875, 0));
    // Angles at the extremes of the field and at the edges of the clamp.
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_BASE, 32767, 0, 0, 0, 0, 0, 0,
                                1, 2500, 1875, 1875, 0));
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_LOWER, -32768, 0, 0, 0, 0, 0, 0,
                                1, 2500, 1250, 1875, 0));
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_UPPER, 90, 0, 0, 0, 0, 0, 0,
                                1, 2500, 1250, 2500, 0));
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_UPPER, -90, 0, 0, 0, 0, 0, 0,
                                1, 2500, 1250, 1250, 0));
    // A zero selector leaves every channel alone.
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_NONE, 45, 0, 0, 0, 0, 0, 0,
                                1, 2500, 1250, 1250, 0));
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_BASE, 0, 0, 0, 0, 0, 0, 0,
                                1, 1875, 1250, 1250, 0));
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_LOWER, 91, 0, 0, 0, 0, 0, 0,
                                1, 1875, 2500, 1250, 0));
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_LOWER, -91, 0, 0, 0, 0, 0, 0,
                                1, 1875, 1250, 1250, 0));
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_UPPER, 1, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    // Upward ramp on base, a downward overshoot on lower, a zero step on upper.
    dir_table.push_back(dir_row(ACT_START, JSEL_NONE, 0, 2000, 1000, 1250, 50,
                                65535, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(ACT_TICK, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(ACT_TICK, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    // Set angle in the middle of a movement; base keeps ramping from there.
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_BASE, -45, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(ACT_TICK, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(ACT_HOLD, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    // Base lands exactly on its destination and is done one tick later;
    // upper steps down by more than its value and clamps to zero.
    dir_table.push_back(dir_row(ACT_ANGLE, JSEL_BASE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(ACT_START, JSEL_NONE, 0, 1975, 65535, 0, 100, 1,
                                65535, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(ACT_TICK, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(ACT_TICK, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    // Largest steps toward the top of the range: the sum would wrap.
    dir_table.push_back(dir_row(ACT_START, JSEL_NONE, 0, 65535, 65535, 65535,
                                65535, 65535, 65535, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(ACT_TICK, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    // All steps zero: every channel is done at once.
    dir_table.push_back(dir_row(ACT_START, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));
    // Started at the destination already: the next tick only marks done.
    dir_table.push_back(dir_row(ACT_START, JSEL_NONE, 0, 65535, 65535, 65535, 5, 5,
                                5, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(ACT_TICK, JSEL_NONE, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[i]) begin
      send_cmd(dir_table[i].cmd, dir_table[i].typed, dir_table[i].golden);
    end

    // Random part. Every item sent counts toward the total, including the
    // no-op action and a set angle with no channel selected.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= QUIET_FROM) begin
        quiet = 1'b1;
      end
      c = random_cmd();
      send_cmd(c, 1'b0, none);
      counted++;
    end
    in_tvalid = 1'b0;

    // Drain, then keep waiting for anything the core might still emit.
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      n_fail++;
    end

    $display("Run covered %0d ticks, %0d starts, %0d set-angle and %0d no-op items.",
             n_tick, n_start, n_angle, n_hold);
    $display("%0d results compared, %0d field mismatches.", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/srvramp_pkg.sv
rtl/servo_ramp_controller_3ch_core.sv
dv/tb.sv
